FILE: rtl/rc4_stream_cipher_macros.svh
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// checked only outside reset
`define RC4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define RC4_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rc4_pkg.sv
package rc4_pkg;

  localparam int MAX_KEY_LEN = 32;
  localparam int PERM_SIZE   = 256;
  localparam int KEY_IDX_W   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int KEY_CNT_W   = $clog2(MAX_KEY_LEN + 1);

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_DAT_RDI = 4'd1,
    OP_DAT_RDJ = 4'd2,
    OP_DAT_SWI = 4'd3,
    OP_DAT_SWJ = 4'd4,
    OP_KEY_RD  = 4'd5,
    OP_KEY_ACC = 4'd6,
    OP_KEY_SWN = 4'd7,
    OP_KEY_SWA = 4'd8
  } dp_op_t;

  typedef struct packed {
    logic   key_we;
    logic   sched_start;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sched_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/rc4_in_if.sv
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;
  logic       key_last;

  modport source (output valid, output cmd, output in_byte, output key_last, input ready);
  modport sink (input valid, input cmd, input in_byte, input key_last, output ready);
endinterface

FILE: rtl/rc4_out_if.sv
interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

FILE: rtl/rc4_stream_cipher.sv
// data request: accepted in idle, then states RDJ, SWI and SWJ, which loads the result
// register and returns to idle; SWJ waits while the result register is still held by the sink
// key request: taken in idle; the last key byte starts a key schedule
// (256 steps of RD, ACC, SWN, SWA; the permutation memory has a read and a write port)
// reset (synchronous): indices and key count cleared, permutation back to identity at once
module rc4_stream_cipher import rc4_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rc4_in_if.sink     req,
  rc4_out_if.source  rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_cmd      (req.cmd),
    .req_key_last (req.key_last),
    .req_ready    (req.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  rc4_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_byte   (req.in_byte),
    .stat      (stat),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_byte  (rsp.out_byte)
  );

endmodule

FILE: rtl/rc4_ctrl.sv
module rc4_ctrl import rc4_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_cmd,
  input  logic     req_key_last,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_DAT_RDJ = 8'b0000_0010,
    ST_DAT_SWI = 8'b0000_0100,
    ST_DAT_SWJ = 8'b0000_1000,
    ST_KEY_RD  = 8'b0001_0000,
    ST_KEY_ACC = 8'b0010_0000,
    ST_KEY_SWN = 8'b0100_0000,
    ST_KEY_SWA = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next      = state;
    cmd.key_we      = 1'b0;
    cmd.sched_start = 1'b0;
    cmd.op          = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_cmd == CMD_DATA) begin
            cmd.op     = OP_DAT_RDI;
            state_next = ST_DAT_RDJ;
          end else begin
            cmd.key_we = 1'b1;
            if (req_key_last) begin
              cmd.sched_start = 1'b1;
              state_next      = ST_KEY_RD;
            end
          end
        end
      end
      ST_DAT_RDJ: begin
        cmd.op     = OP_DAT_RDJ;
        state_next = ST_DAT_SWI;
      end
      ST_DAT_SWI: begin
        cmd.op     = OP_DAT_SWI;
        state_next = ST_DAT_SWJ;
      end
      ST_DAT_SWJ: begin
        cmd.op = OP_DAT_SWJ;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_KEY_RD: begin
        cmd.op     = OP_KEY_RD;
        state_next = ST_KEY_ACC;
      end
      ST_KEY_ACC: begin
        cmd.op     = OP_KEY_ACC;
        state_next = ST_KEY_SWN;
      end
      ST_KEY_SWN: begin
        cmd.op     = OP_KEY_SWN;
        state_next = ST_KEY_SWA;
      end
      ST_KEY_SWA: begin
        cmd.op     = OP_KEY_SWA;
        state_next = stat.sched_done ? ST_IDLE : ST_KEY_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/rc4_dp.sv
module rc4_dp import rc4_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  input  logic [7:0] in_byte,
  output dp_stat_t   stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  // permutation memory, entries not yet written read as identity
  logic [7:0]           perm_mem [PERM_SIZE];
  logic [PERM_SIZE-1:0] perm_vld;
  logic                 rd_en;
  logic [7:0]           rd_addr;
  logic [7:0]           rd_q;
  logic [7:0]           rd_addr_q;
  logic                 rd_vld_q;
  logic [7:0]           rd_val;
  logic                 wr_en;
  logic [7:0]           wr_addr;
  logic [7:0]           wr_data;

  logic [7:0]           key_mem [MAX_KEY_LEN];
  logic [7:0]           key_q;
  logic [KEY_CNT_W-1:0] key_count;
  logic [KEY_CNT_W-1:0] key_len;
  logic                 key_room;
  logic [KEY_IDX_W-1:0] kpos;
  logic [KEY_CNT_W-1:0] kpos_inc;

  logic [7:0] idx_i;
  logic [7:0] idx_j;
  logic [7:0] sched_n;
  logic [7:0] acc;
  logic [7:0] byte_q;
  logic [7:0] si_q;
  logic [7:0] sj_q;
  logic [7:0] j_new;
  logic [7:0] acc_new;
  logic [7:0] ks;
  logic       out_load;

  assign rd_val   = rd_vld_q ? rd_q : rd_addr_q;
  assign key_room = key_count < KEY_CNT_W'(MAX_KEY_LEN);
  assign kpos_inc = KEY_CNT_W'(kpos) + KEY_CNT_W'(1);
  assign j_new    = idx_j + rd_val;
  assign acc_new  = acc + rd_val + key_q;

  // keystream byte after the swap of i and j
  always_comb begin
    if (rd_addr_q == idx_i) begin
      ks = sj_q;
    end else if (rd_addr_q == idx_j) begin
      ks = si_q;
    end else begin
      ks = rd_val;
    end
  end

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.sched_done = (sched_n == 8'hFF);
  assign out_load        = (cmd.op == OP_DAT_SWJ) && stat.out_free;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sched_n;
    wr_en   = 1'b0;
    wr_addr = idx_i;
    wr_data = rd_val;
    case (cmd.op)
      OP_DAT_RDI: begin
        rd_en   = 1'b1;
        rd_addr = idx_i + 8'd1;
      end
      OP_DAT_RDJ: begin
        rd_en   = 1'b1;
        rd_addr = j_new;
      end
      OP_DAT_SWI: begin
        rd_en   = 1'b1;
        rd_addr = si_q + rd_val;
        wr_en   = 1'b1;
        wr_addr = idx_i;
        wr_data = rd_val;
      end
      OP_DAT_SWJ: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = si_q;
      end
      OP_KEY_RD: begin
        rd_en   = 1'b1;
        rd_addr = sched_n;
      end
      OP_KEY_ACC: begin
        rd_en   = 1'b1;
        rd_addr = acc_new;
      end
      OP_KEY_SWN: begin
        wr_en   = 1'b1;
        wr_addr = sched_n;
        wr_data = rd_val;
      end
      OP_KEY_SWA: begin
        wr_en   = 1'b1;
        wr_addr = acc;
        wr_data = si_q;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= perm_mem[rd_addr];
      rd_vld_q  <= perm_vld[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.sched_start) begin
      perm_vld <= '0;
    end else if (wr_en) begin
      perm_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_we && key_room) begin
      key_mem[key_count[KEY_IDX_W-1:0]] <= in_byte;
    end
    if (cmd.op == OP_KEY_RD) begin
      key_q <= key_mem[kpos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cmd.sched_start) begin
      key_count <= '0;
    end else if (cmd.key_we && key_room) begin
      key_count <= key_count + KEY_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i <= '0;
      idx_j <= '0;
    end else if (cmd.sched_start) begin
      idx_i <= '0;
      idx_j <= '0;
    end else if (cmd.op == OP_DAT_RDI) begin
      idx_i <= idx_i + 8'd1;
    end else if (cmd.op == OP_DAT_RDJ) begin
      idx_j <= j_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched_start) begin
      key_len <= key_room ? key_count + KEY_CNT_W'(1) : key_count;
      sched_n <= '0;
      acc     <= '0;
      kpos    <= '0;
    end
    case (cmd.op)
      OP_DAT_RDI: begin
        byte_q <= in_byte;
      end
      OP_DAT_RDJ: begin
        si_q <= rd_val;
      end
      OP_DAT_SWI: begin
        sj_q <= rd_val;
      end
      OP_KEY_ACC: begin
        acc  <= acc_new;
        si_q <= rd_val;
      end
      OP_KEY_SWA: begin
        sched_n <= sched_n + 8'd1;
        kpos    <= (kpos_inc >= key_len) ? '0 : kpos_inc[KEY_IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= byte_q ^ ks;
    end
  end

endmodule

FILE: rtl/rc4_checker.sv
`include "rc4_stream_cipher_macros.svh"

module rc4_checker import rc4_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_cmd,
  input logic       req_key_last,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_out_byte
);

  logic req_accept;

  assign req_accept = req_valid && req_ready;

  `RC4_ASSERT_ALWAYS(a_rsp_idle_after_rst, rst |=> !rsp_valid, "result valid right after reset")
  `RC4_ASSERT(a_busy_after_data, req_accept && (req_cmd == CMD_DATA) |=> !req_ready, "ready after data request")
  `RC4_ASSERT(a_busy_after_last, req_accept && (req_cmd == CMD_KEY) && req_key_last |=> !req_ready, "ready during key schedule")
  `RC4_ASSERT(a_key_byte_one_cycle, req_accept && (req_cmd == CMD_KEY) && !req_key_last |=> req_ready, "key byte stalls")
  `RC4_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte), "stalled result changed")

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_cmd      (req.cmd),
  .req_key_last (req.key_last),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_out_byte (rsp.out_byte)
);
